@@ hw/rtl/ffdl_pkg.sv @@
`default_nettype none

package ffdl_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int FILL_W    = MEM_AW + 1;

    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IW    = 2;
    localparam int MUL_AW    = 25;
    localparam int MUL_BW    = 18;
    localparam int PROD_W    = MUL_AW + MUL_BW;
    localparam int SUM_W     = 30;

    typedef logic [MEM_AW-1:0]          t_addr;
    typedef logic [FILL_W-1:0]          t_fill;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MUL_AW-1:0]   t_mop_a;
    typedef logic signed [MUL_BW-1:0]   t_mop_b;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [CFG_W:0]             t_gain;

    localparam t_addr   ADDR_LAST  = t_addr'(MEM_DEPTH - 1);
    localparam t_fill   FILL_FULL  = t_fill'(MEM_DEPTH);
    localparam t_gain   UNITY      = t_gain'(32768);
    localparam t_prod   RND_16     = t_prod'(32768);
    localparam t_prod   RND_15     = t_prod'(16384);
    localparam t_sum    SAT_MAX    = t_sum'(8388607);
    localparam t_sum    SAT_MIN    = -t_sum'(8388608);

    typedef enum logic [CFG_IW-1:0] {
        CFG_DELAY_WHOLE    = 2'd0,
        CFG_DELAY_FRACTION = 2'd1,
        CFG_FEEDBACK_GAIN  = 2'd2,
        CFG_WET_LEVEL      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDB,
        S_RDA,
        S_CAPA,
        S_MDIF,
        S_DLY,
        S_MFB,
        S_WR,
        S_MDRY,
        S_MIX
    } t_state;

    typedef struct packed {
        logic   en;
        t_mop_a a;
        t_mop_b b;
    } t_mul_req;

    function automatic t_sample sat_sample(input t_sum v);
        t_sample res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[SAMPLE_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ffdl_ram.sv @@
`default_nettype none

module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ffdl_mul.sv @@
`default_nettype none

module ffdl_mul (
    input  wire logic               i_clk,
    input  wire ffdl_pkg::t_mul_req i_req,
    output ffdl_pkg::t_prod         o_prod
);

    ffdl_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hw/rtl/fractional_feedback_delay_line_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata[23:0] sample_in
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata[23:0] sample_out
// cfg       in   i_cfg_valid/o_cfg_ready           index[1:0], data[15:0]
//
// Each sample goes through idle/accept, two delay memory reads on its single
// read port, then four products through one shared 25x18 multiplier.
// The next sample is taken while a finished result waits in the output register.
// Reset is synchronous; memory reads beyond the fill count return zero, so no
// clearing pass is needed. Config registers are always ready.

module fractional_feedback_delay_line_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [ffdl_pkg::SAMPLE_W-1:0]         i_s_axis_tdata,  // [23:0] sample_in
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic      [ffdl_pkg::SAMPLE_W-1:0]         o_m_axis_tdata,  // [23:0] sample_out
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ffdl_pkg::CFG_IW-1:0]           i_cfg_index,
    input  wire logic [ffdl_pkg::CFG_W-1:0]            i_cfg_data
);

    ffdl_pkg::t_state   r_state, n_state;
    logic [ffdl_pkg::CFG_W-1:0] r_whole, r_frac, r_gain, r_wet;

    ffdl_pkg::t_addr    r_wp, n_wp;
    ffdl_pkg::t_fill    r_fill, n_fill;
    ffdl_pkg::t_addr    r_rp, n_rp;
    ffdl_pkg::t_addr    r_older, n_older;
    logic               r_zero, n_zero;
    ffdl_pkg::t_sample  r_x, n_x;
    ffdl_pkg::t_sample  r_a, n_a;
    ffdl_pkg::t_sample  r_b, n_b;
    ffdl_pkg::t_sample  r_delayed, n_delayed;
    ffdl_pkg::t_prod    r_acc, n_acc;
    logic               r_ovalid, n_ovalid;
    ffdl_pkg::t_sample  r_odata, n_odata;

    logic [31:0]        w_whole32;
    ffdl_pkg::t_addr    w_whole_c;
    ffdl_pkg::t_fill    w_diff;
    ffdl_pkg::t_addr    w_rp;
    ffdl_pkg::t_gain    w_wet_c;
    ffdl_pkg::t_gain    w_dry;
    logic               w_accept;

    ffdl_pkg::t_mul_req w_mreq;
    ffdl_pkg::t_prod    w_prod;
    ffdl_pkg::t_prod    w_rnd16, w_rnd15, w_mix, w_mix_rnd;
    ffdl_pkg::t_prod    w_sh16, w_sh15, w_shmix;
    ffdl_pkg::t_sum     w_dly_sum, w_fed, w_mix_sum;

    logic               w_ram_we;
    ffdl_pkg::t_addr    w_raddr;
    ffdl_pkg::t_sample  w_rdata;
    ffdl_pkg::t_sample  w_wdata;

    ffdl_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    ffdl_ram #(
        .WIDTH (ffdl_pkg::SAMPLE_W),
        .DEPTH (ffdl_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ffdl_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // read position from write pointer and clamped whole delay; clamped wet and dry levels
    always_comb begin
        w_whole32 = 32'(r_whole);
        w_whole_c = (w_whole32 >= 32'(ffdl_pkg::MEM_DEPTH)) ? ffdl_pkg::ADDR_LAST
                                                             : w_whole32[ffdl_pkg::MEM_AW-1:0];
        w_diff    = {1'b0, r_wp} - {1'b0, w_whole_c};
        w_rp      = w_diff[ffdl_pkg::MEM_AW] ? ffdl_pkg::t_addr'(w_diff + ffdl_pkg::FILL_FULL)
                                             : w_diff[ffdl_pkg::MEM_AW-1:0];
        w_wet_c   = ({1'b0, r_wet} > ffdl_pkg::UNITY) ? ffdl_pkg::UNITY : {1'b0, r_wet};
        w_dry     = ffdl_pkg::UNITY - w_wet_c;
    end

    always_comb begin
        w_rnd16   = w_prod + ffdl_pkg::RND_16;
        w_rnd15   = w_prod + ffdl_pkg::RND_15;
        w_sh16    = w_rnd16 >>> 16;
        w_sh15    = w_rnd15 >>> 15;
        w_dly_sum = ffdl_pkg::t_sum'(r_a) + w_sh16[ffdl_pkg::SUM_W-1:0];
        w_fed     = ffdl_pkg::t_sum'(r_x) + w_sh15[ffdl_pkg::SUM_W-1:0];
        w_wdata   = ffdl_pkg::sat_sample(w_fed);
        w_mix     = r_acc + w_prod;
        w_mix_rnd = w_mix + ffdl_pkg::RND_15;
        w_shmix   = w_mix_rnd >>> 15;
        w_mix_sum = w_shmix[ffdl_pkg::SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole <= '0;
            r_frac  <= '0;
            r_gain  <= '0;
            r_wet   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ffdl_pkg::t_cfg_idx'(i_cfg_index))
                ffdl_pkg::CFG_DELAY_WHOLE:    r_whole <= i_cfg_data;
                ffdl_pkg::CFG_DELAY_FRACTION: r_frac  <= i_cfg_data;
                ffdl_pkg::CFG_FEEDBACK_GAIN:  r_gain  <= i_cfg_data;
                ffdl_pkg::CFG_WET_LEVEL:      r_wet   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffdl_pkg::S_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rp      <= n_rp;
        r_older   <= n_older;
        r_zero    <= n_zero;
        r_x       <= n_x;
        r_a       <= n_a;
        r_b       <= n_b;
        r_delayed <= n_delayed;
        r_acc     <= n_acc;
        r_odata   <= n_odata;
    end

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_rp      = r_rp;
        n_older   = r_older;
        n_zero    = r_zero;
        n_x       = r_x;
        n_a       = r_a;
        n_b       = r_b;
        n_delayed = r_delayed;
        n_acc     = r_acc;
        n_odata   = r_odata;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        w_ram_we  = 1'b0;
        w_raddr   = r_rp;
        w_mreq    = '{en: 1'b0, a: '0, b: '0};

        case (r_state)
            ffdl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_x     = i_s_axis_tdata;
                    n_rp    = w_rp;
                    n_older = (w_rp == '0) ? ffdl_pkg::ADDR_LAST : w_rp - 1'b1;
                    n_zero  = (r_whole == '0);
                    n_state = ffdl_pkg::S_RDB;
                end
            end
            ffdl_pkg::S_RDB: begin
                w_raddr = r_older;
                n_state = ffdl_pkg::S_RDA;
            end
            ffdl_pkg::S_RDA: begin
                w_raddr = r_rp;
                n_b     = ({1'b0, r_older} < r_fill) ? w_rdata : '0;
                n_state = ffdl_pkg::S_CAPA;
            end
            ffdl_pkg::S_CAPA: begin
                if (r_zero) begin
                    n_a = r_x;
                end else begin
                    n_a = ({1'b0, r_rp} < r_fill) ? w_rdata : '0;
                end
                n_state = ffdl_pkg::S_MDIF;
            end
            ffdl_pkg::S_MDIF: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = ffdl_pkg::t_mop_a'(r_b) - ffdl_pkg::t_mop_a'(r_a);
                w_mreq.b  = $signed({2'b00, r_frac});
                n_state   = ffdl_pkg::S_DLY;
            end
            ffdl_pkg::S_DLY: begin
                n_delayed = w_dly_sum[ffdl_pkg::SAMPLE_W-1:0];
                n_state   = ffdl_pkg::S_MFB;
            end
            ffdl_pkg::S_MFB: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = ffdl_pkg::t_mop_a'(r_delayed);
                w_mreq.b  = $signed({2'b00, r_gain});
                n_state   = ffdl_pkg::S_WR;
            end
            ffdl_pkg::S_WR: begin
                w_ram_we  = 1'b1;
                n_wp      = (r_wp == ffdl_pkg::ADDR_LAST) ? '0 : r_wp + 1'b1;
                n_fill    = (r_fill == ffdl_pkg::FILL_FULL) ? r_fill : r_fill + 1'b1;
                w_mreq.en = 1'b1;
                w_mreq.a  = ffdl_pkg::t_mop_a'(r_delayed);
                w_mreq.b  = $signed({1'b0, w_wet_c});
                n_state   = ffdl_pkg::S_MDRY;
            end
            ffdl_pkg::S_MDRY: begin
                n_acc     = w_prod;
                w_mreq.en = 1'b1;
                w_mreq.a  = ffdl_pkg::t_mop_a'(r_x);
                w_mreq.b  = $signed({1'b0, w_dry});
                n_state   = ffdl_pkg::S_MIX;
            end
            ffdl_pkg::S_MIX: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata  = ffdl_pkg::sat_sample(w_mix_sum);
                    n_ovalid = 1'b1;
                    n_state  = ffdl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffdl_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ffdl_pkg::FILL_FULL)
        else $error("fill count beyond memory depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |=> (r_wp != $past(r_wp)) && (r_fill >= $past(r_fill)))
        else $error("write pointer did not advance after memory write");

    a_out_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ffdl_pkg::S_MIX))
        else $error("output valid raised outside mix step");
`endif

endmodule

`default_nettype wire
